// File: rtl/psd_pkg.sv
// Shared constants, types and region codes for the point to segment distance block.
package psd_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int DIST_BITS      = 25;
	localparam int REGION_W       = 2;

	localparam logic [REGION_W-1:0] REGION_START = 2'd0;
	localparam logic [REGION_W-1:0] REGION_END   = 2'd1;
	localparam logic [REGION_W-1:0] REGION_MID   = 2'd2;

	// Control tag that travels alongside each item through the pipeline.
	typedef struct packed {
		logic                valid;
		logic [REGION_W-1:0] region;
	} tag_t;

endpackage

// File: rtl/psd_front.sv
// Front stages: differences, products, dot sums, region pick and the squared-distance numerator.
module psd_front #(
	parameter int COORD_BITS = 16,
	parameter int SUM_W      = 2 * (COORD_BITS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] pt [3],
	input  logic signed [COORD_BITS-1:0] st [3],
	input  logic signed [COORD_BITS-1:0] nd [3],
	output psd_pkg::tag_t                tag,
	output logic [2*SUM_W-1:0]           num,
	output logic [SUM_W-1:0]             divisor
);
	import psd_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int SW = SUM_W;
	localparam int EW = SW + 1;
	localparam int HB = (SW + 1) / 2;
	localparam int HH = SW - HB;
	localparam int NW = 2 * SW;

	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] v_s1 [3];
	logic signed [DW-1:0] f_s1 [3];

	logic signed [PW-1:0] dv_s2 [3];
	logic signed [PW-1:0] vv_s2 [3];
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] ff_s2 [3];

	logic signed [EW-1:0] e_s3;
	logic [SW-1:0]        len_s3, dd_s3, ff_s3;

	logic [2*HB-1:0]    dl_ll_s4, ee_ll_s4;
	logic [HB+HH-1:0]   dl_lh_s4, dl_hl_s4, ee_lh_s4, ee_hl_s4;
	logic [2*HH-1:0]    dl_hh_s4, ee_hh_s4;
	logic [SW-1:0]      len_s4, sel_s4;

	logic [NW-1:0] dl_s5, ee_s5;
	logic [SW-1:0] len_s5, sel_s5;

	logic [NW-1:0] num_s6;
	logic [SW-1:0] div_s6;

	logic [REGION_W-1:0] region_c;
	logic [SW-1:0]       emag_c;

	// Advance the valid tags; region is settled in stage 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else if (en) begin
			tag_s1 <= '{valid: in_valid, region: REGION_START};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= '{valid: tag_s3.valid, region: region_c};
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	// Pick the nearest part from the projection.
	always_comb begin
		priority if (e_s3 <= 0) begin
			region_c = REGION_START;
		end else if (e_s3[SW-1:0] > len_s3) begin
			region_c = REGION_END;
		end else begin
			region_c = REGION_MID;
		end
	end

	assign emag_c = e_s3[SW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: coordinate differences.
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(pt[i]) - DW'(st[i]);
				v_s1[i] <= DW'(nd[i]) - DW'(st[i]);
				f_s1[i] <= DW'(pt[i]) - DW'(nd[i]);
			end
			// Stage 2: per-axis products.
			for (int i = 0; i < 3; i++) begin
				dv_s2[i] <= d_s1[i] * v_s1[i];
				vv_s2[i] <= v_s1[i] * v_s1[i];
				dd_s2[i] <= d_s1[i] * d_s1[i];
				ff_s2[i] <= f_s1[i] * f_s1[i];
			end
			// Stage 3: dot product sums.
			e_s3   <= EW'(dv_s2[0]) + EW'(dv_s2[1]) + EW'(dv_s2[2]);
			len_s3 <= SW'(vv_s2[0]) + SW'(vv_s2[1]) + SW'(vv_s2[2]);
			dd_s3  <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
			ff_s3  <= SW'(ff_s2[0]) + SW'(ff_s2[1]) + SW'(ff_s2[2]);
			// Stage 4: half-width partial products of dd*L and e*e.
			dl_ll_s4 <= dd_s3[HB-1:0] * len_s3[HB-1:0];
			dl_lh_s4 <= dd_s3[HB-1:0] * len_s3[SW-1:HB];
			dl_hl_s4 <= dd_s3[SW-1:HB] * len_s3[HB-1:0];
			dl_hh_s4 <= dd_s3[SW-1:HB] * len_s3[SW-1:HB];
			ee_ll_s4 <= emag_c[HB-1:0] * emag_c[HB-1:0];
			ee_lh_s4 <= emag_c[HB-1:0] * emag_c[SW-1:HB];
			ee_hl_s4 <= emag_c[SW-1:HB] * emag_c[HB-1:0];
			ee_hh_s4 <= emag_c[SW-1:HB] * emag_c[SW-1:HB];
			len_s4   <= len_s3;
			sel_s4   <= (region_c == REGION_END) ? ff_s3 : dd_s3;
			// Stage 5: combine partial products.
			dl_s5  <= (NW'(dl_hh_s4) << (2 * HB))
				+ ((NW'(dl_hl_s4) + NW'(dl_lh_s4)) << HB) + NW'(dl_ll_s4);
			ee_s5  <= (NW'(ee_hh_s4) << (2 * HB))
				+ ((NW'(ee_hl_s4) + NW'(ee_lh_s4)) << HB) + NW'(ee_ll_s4);
			len_s5 <= len_s4;
			sel_s5 <= sel_s4;
			// Stage 6: numerator and divisor; endpoints divide by one.
			if (tag_s5.region == REGION_MID) begin
				num_s6 <= dl_s5 - ee_s5;
				div_s6 <= len_s5;
			end else begin
				num_s6 <= NW'(sel_s5);
				div_s6 <= SW'(1);
			end
		end
	end

	assign tag     = tag_s6;
	assign num     = num_s6;
	assign divisor = div_s6;

endmodule

// File: rtl/psd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with the fixed point scaling.
module psd_div #(
	parameter int SUM_W     = 34,
	parameter int FRAC_BITS = 8,
	parameter int QUOT_W    = SUM_W + 2 * FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  psd_pkg::tag_t        tag_in,
	input  logic [2*SUM_W-1:0]   num,
	input  logic [SUM_W-1:0]     divisor,
	output psd_pkg::tag_t        tag_out,
	output logic [QUOT_W-1:0]    quot
);
	import psd_pkg::*;

	localparam int SW  = SUM_W;
	localparam int QW  = QUOT_W;
	localparam int NWF = 2 * SW + 2 * FRAC_BITS;

	logic [NWF-1:0] scaled;
	logic [SW-1:0]  r_s [0:QW];
	logic [QW-1:0]  w_s [0:QW];
	logic [SW-1:0]  d_s [0:QW-1];
	tag_t           t_s [0:QW];

	// Scale the numerator; its top part starts the remainder.
	assign scaled = NWF'(num) << (2 * FRAC_BITS);
	assign r_s[0] = scaled[NWF-1:QW];
	assign w_s[0] = scaled[QW-1:0];
	assign d_s[0] = divisor;
	assign t_s[0] = tag_in;

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [SW:0] trial;
		logic [SW:0] diff;
		logic        ge;

		assign trial = {r_s[k], w_s[k][QW-1]};
		assign diff  = trial - {1'b0, d_s[k]};
		assign ge    = trial >= {1'b0, d_s[k]};

		// Advance the tag.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_s[k+1] <= '0;
			end else if (en) begin
				t_s[k+1] <= t_s[k];
			end
		end

		// Subtract when it fits and shift the quotient bit in.
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= ge ? diff[SW-1:0] : trial[SW-1:0];
				w_s[k+1] <= {w_s[k][QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					d_s[k+1] <= d_s[k];
				end
			end
		end
	end

	assign tag_out = t_s[QW];
	assign quot    = w_s[QW];

endmodule

// File: rtl/psd_sqrt.sv
// Pipelined floor square root, one root bit per stage, with saturation of oversize values.
module psd_sqrt #(
	parameter int QUOT_W = 50
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  psd_pkg::tag_t                  tag_in,
	input  logic [QUOT_W-1:0]              rad,
	output psd_pkg::tag_t                  tag_out,
	output logic [psd_pkg::DIST_BITS-1:0]  root
);
	import psd_pkg::*;

	localparam int DB = DIST_BITS;
	localparam int RW = DB + 3;
	localparam int XW = QUOT_W + 2 * DB;

	logic [XW-1:0]   rad_x;
	logic [RW-1:0]   rem_s  [0:DB];
	logic [DB-1:0]   root_s [0:DB];
	logic [2*DB-1:0] rad_s  [0:DB-1];
	logic            sat_s  [0:DB];
	tag_t            t_s    [0:DB];

	// Flag values too large for the result and start the recurrence.
	assign rad_x     = XW'(rad);
	assign sat_s[0]  = (rad_x >> (2 * DB)) != '0;
	assign rad_s[0]  = rad_x[2*DB-1:0];
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign t_s[0]    = tag_in;

	for (genvar k = 0; k < DB; k++) begin : g_step
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		assign cur   = {rem_s[k][RW-3:0], rad_s[k][2*DB-1:2*DB-2]};
		assign trial = RW'({root_s[k], 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_s[k+1] <= '0;
			end else if (en) begin
				t_s[k+1] <= t_s[k];
			end
		end

		// Take one root bit.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (cur - trial) : cur;
				root_s[k+1] <= {root_s[k][DB-2:0], ge};
				sat_s[k+1]  <= sat_s[k];
			end
		end

		if (k < DB - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k+1] <= {rad_s[k][2*DB-3:0], 2'b00};
				end
			end
		end
	end

	assign tag_out = t_s[DB];
	assign root    = sat_s[DB] ? '1 : root_s[DB];

endmodule

// File: rtl/point_segment_distance_3d.sv
// Top level: point to segment distance pipeline with an output register and skid stage.
// Throughput: one item per cycle while the skid stage is empty; the divider and root
// units take one bit per stage. in_ready is low exactly while the skid stage holds an item.
// Reset clears all valid bits, including the output and skid flags; data is not reset.
module point_segment_distance_3d #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COORD_BITS-1:0]   point_x,
	input  logic signed [COORD_BITS-1:0]   point_y,
	input  logic signed [COORD_BITS-1:0]   point_z,
	input  logic signed [COORD_BITS-1:0]   start_x,
	input  logic signed [COORD_BITS-1:0]   start_y,
	input  logic signed [COORD_BITS-1:0]   start_z,
	input  logic signed [COORD_BITS-1:0]   end_x,
	input  logic signed [COORD_BITS-1:0]   end_y,
	input  logic signed [COORD_BITS-1:0]   end_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [psd_pkg::DIST_BITS-1:0]  distance,
	output logic [psd_pkg::REGION_W-1:0]   region
);
	import psd_pkg::*;

	localparam int SW = 2 * (COORD_BITS + 1);
	localparam int QW = SW + 2 * FRAC_BITS;

	logic signed [COORD_BITS-1:0] pt [3];
	logic signed [COORD_BITS-1:0] st [3];
	logic signed [COORD_BITS-1:0] nd [3];

	logic                  en;
	tag_t                  front_tag, div_tag, sqrt_tag;
	logic [2*SW-1:0]       num;
	logic [SW-1:0]         divisor;
	logic [QW-1:0]         quot;
	logic [DIST_BITS-1:0]  root;

	logic                  out_valid_q, skid_valid_q;
	logic [DIST_BITS-1:0]  out_dist_q, skid_dist_q;
	logic [REGION_W-1:0]   out_region_q, skid_region_q;
	logic                  pop;

	assign pt = '{point_x, point_y, point_z};
	assign st = '{start_x, start_y, start_z};
	assign nd = '{end_x, end_y, end_z};

	// Advance the whole pipeline while the skid stage is empty.
	assign en       = !skid_valid_q;
	assign in_ready = en;

	psd_front #(
		.COORD_BITS(COORD_BITS),
		.SUM_W     (SW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.pt      (pt),
		.st      (st),
		.nd      (nd),
		.tag     (front_tag),
		.num     (num),
		.divisor (divisor)
	);

	psd_div #(
		.SUM_W    (SW),
		.FRAC_BITS(FRAC_BITS),
		.QUOT_W   (QW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (front_tag),
		.num    (num),
		.divisor(divisor),
		.tag_out(div_tag),
		.quot   (quot)
	);

	psd_sqrt #(
		.QUOT_W(QW)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (div_tag),
		.rad    (quot),
		.tag_out(sqrt_tag),
		.root   (root)
	);

	assign pop = out_valid_q && out_ready;

	// Output register and skid stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q  <= skid_valid_q || (en && sqrt_tag.valid);
				skid_valid_q <= 1'b0;
			end else if (!out_valid_q) begin
				out_valid_q <= en && sqrt_tag.valid;
			end else if (en && sqrt_tag.valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output register and skid stage data.
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_dist_q   <= skid_dist_q;
			out_region_q <= skid_region_q;
		end else if (pop || !out_valid_q) begin
			out_dist_q   <= root;
			out_region_q <= sqrt_tag.region;
		end
		if (!pop && out_valid_q && en && sqrt_tag.valid) begin
			skid_dist_q   <= root;
			skid_region_q <= sqrt_tag.region;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = out_dist_q;
	assign region    = out_region_q;

	// The skid stage only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while the output register is empty");

	// A full skid stage freezes the pipeline until the output transfers.
	a_skid_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_ready) |=> (skid_valid_q && $stable(skid_dist_q)))
		else $error("skid stage lost its item under a stall");

	// Delivered regions are one of the three codes.
	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_region_q == REGION_START || out_region_q == REGION_END
			|| out_region_q == REGION_MID))
		else $error("invalid region code delivered");

endmodule
